[src/apsm_pkg.sv]
`default_nettype none
package apsm_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam logic [15:0] ARTIM_RESET = 16'd1000;

   // event codes
   typedef enum logic [4:0] {
      EV_RQ_L = 5'd0, EV_RQ_R = 5'd1, EV_AC_L = 5'd2, EV_AC_R = 5'd3,
      EV_RJ_L = 5'd4, EV_RJ_R = 5'd5, EV_DT_L = 5'd6, EV_DT_R = 5'd7,
      EV_RELRQ_L = 5'd8, EV_RELRQ_R = 5'd9, EV_RELRP_L = 5'd10, EV_RELRP_R = 5'd11,
      EV_AB_L = 5'd12, EV_AB_R = 5'd13, EV_TC_IND = 5'd14, EV_TC_CONF = 5'd15,
      EV_TC_CLOSED = 5'd16, EV_ARTIM = 5'd17, EV_INVALID = 5'd18
   } event_type;

   // func codes
   localparam logic [2:0] FUNC_SEND = 3'd0;
   localparam logic [2:0] FUNC_RECV = 3'd1;
   localparam logic [2:0] FUNC_TC_IND = 3'd2;
   localparam logic [2:0] FUNC_TC_CLOSED = 3'd3;
   localparam logic [2:0] FUNC_TICK = 3'd4;

   // action codes
   localparam logic [4:0] AE1 = 5'd0, AE2 = 5'd1, AE3 = 5'd2, AE4 = 5'd3, AE5 = 5'd4,
      AE6 = 5'd5, AE7 = 5'd6, AE8 = 5'd7, DT1 = 5'd8, DT2 = 5'd9, AR1 = 5'd10,
      AR2 = 5'd11, AR3 = 5'd12, AR4 = 5'd13, AR5 = 5'd14, AR6 = 5'd15, AR7 = 5'd16,
      AR8 = 5'd17, AR9 = 5'd18, AR10 = 5'd19, AA1 = 5'd20, AA2 = 5'd21, AA3 = 5'd22,
      AA4 = 5'd23, AA5 = 5'd24, AA6 = 5'd25, AA7 = 5'd26, AA8 = 5'd27;

   localparam logic [2:0] PDU_ABORT = 3'd7;
   localparam logic [1:0] TCMD_NONE = 2'd0, TCMD_START = 2'd1, TCMD_STOP = 2'd2;
   localparam logic [1:0] XCMD_NONE = 2'd0, XCMD_OPEN = 2'd1, XCMD_CLOSE = 2'd2;
   localparam logic [2:0] ST_NONE = 3'd0, ST_CONN = 3'd1, ST_ASSOC = 3'd2,
      ST_REJ = 3'd3, ST_REL = 3'd4, ST_ABORT = 3'd5, ST_CLOSED = 3'd6;
   localparam logic [2:0] IND_NONE = 3'd0, IND_AC = 3'd1, IND_RQ = 3'd2,
      IND_RJ = 3'd3, IND_DATA = 3'd4;
   localparam logic [7:0] CSR_ARTIM = 8'd0;

   // one transition outcome
   typedef struct packed {
      logic [3:0] new_state;
      logic [4:0] action_code;
      logic [2:0] send_pdu_type;
      logic [7:0] abort_source;
      logic [7:0] abort_reason;
      logic [1:0] timer_cmd;
      logic [1:0] transport_cmd;
      logic [2:0] status;
      logic [2:0] indication;
      logic       no_transition;
   } result_type;

   function automatic logic is_remote(input event_type ev);
      return ev == EV_AC_R || ev == EV_RJ_R || ev == EV_RQ_R || ev == EV_DT_R ||
             ev == EV_RELRQ_R || ev == EV_RELRP_R;
   endfunction

endpackage
`default_nettype wire

[src/apsm_step.sv]
`default_nettype none
// one transition: table lookup and action decode
module apsm_step (
   input  wire logic [3:0]              cur_state,
   input  wire apsm_pkg::event_type     ev,
   input  wire logic [2:0]              base_status,
   input  wire logic                    accept,
   input  wire logic [7:0]              item_src,
   input  wire logic [7:0]              item_rsn,
   input  wire logic [7:0]              stored_src,
   input  wire logic [7:0]              stored_rsn,
   output apsm_pkg::result_type         res
);
   import apsm_pkg::*;

   logic       ok;
   logic [4:0] act;
   logic [3:0] nxt;
   logic       rem;

   // transition table
   always_comb begin
      rem = is_remote(ev) || ev == EV_INVALID;
      ok  = 1'b1;
      act = AE1;
      nxt = cur_state;
      case (cur_state)
         4'd1: begin
            if (ev == EV_RQ_L) begin act = AE1; nxt = 4'd4; end
            else if (ev == EV_TC_IND) begin act = AE5; nxt = 4'd2; end
            else ok = 1'b0;
         end
         4'd2: begin
            if (ev == EV_RQ_R) begin act = AE6; nxt = 4'd3; end
            else if (rem) begin act = AA1; nxt = 4'd13; end
            else if (ev == EV_AB_R || ev == EV_ARTIM) begin act = AA2; nxt = 4'd1; end
            else if (ev == EV_TC_CLOSED) begin act = AA5; nxt = 4'd1; end
            else ok = 1'b0;
         end
         4'd4: begin
            if (ev == EV_TC_CONF) begin act = AE2; nxt = 4'd5; end
            else if (ev == EV_AB_L) begin act = AA2; nxt = 4'd1; end
            else if (ev == EV_TC_CLOSED) begin act = AA4; nxt = 4'd1; end
            else ok = 1'b0;
         end
         4'd13: begin
            if (ev == EV_RQ_R || ev == EV_INVALID) begin act = AA7; nxt = 4'd13; end
            else if (rem) begin act = AA6; nxt = 4'd13; end
            else if (ev == EV_AB_R || ev == EV_ARTIM) begin act = AA2; nxt = 4'd1; end
            else if (ev == EV_TC_CLOSED) begin act = AR5; nxt = 4'd1; end
            else ok = 1'b0;
         end
         4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12: begin
            if (cur_state == 4'd3 && ev == EV_AC_L) begin act = AE7; nxt = 4'd6; end
            else if (cur_state == 4'd3 && ev == EV_RJ_L) begin act = AE8; nxt = 4'd13; end
            else if (cur_state == 4'd5 && ev == EV_AC_R) begin act = AE3; nxt = 4'd6; end
            else if (cur_state == 4'd5 && ev == EV_RJ_R) begin act = AE4; nxt = 4'd1; end
            else if (cur_state == 4'd6 && ev == EV_DT_L) begin act = DT1; nxt = 4'd6; end
            else if (cur_state == 4'd6 && ev == EV_DT_R) begin act = DT2; nxt = 4'd6; end
            else if (cur_state == 4'd6 && ev == EV_RELRQ_L) begin
               act = AR1; nxt = 4'd7;
            end
            else if (cur_state == 4'd6 && ev == EV_RELRQ_R) begin
               act = AR2; nxt = 4'd8;
            end
            else if (cur_state == 4'd7 && ev == EV_DT_R) begin act = AR6; nxt = 4'd7; end
            else if (cur_state == 4'd7 && ev == EV_RELRQ_R) ok = 1'b0;
            else if ((cur_state == 4'd7 || cur_state == 4'd11) && ev == EV_RELRP_R) begin
               act = AR3; nxt = 4'd1;
            end
            else if (cur_state == 4'd8 && ev == EV_DT_L) begin act = AR7; nxt = 4'd8; end
            else if ((cur_state == 4'd8 || cur_state == 4'd12) && ev == EV_RELRP_L) begin
               act = AR4; nxt = 4'd13;
            end
            else if (cur_state == 4'd9 && ev == EV_RELRP_L) begin
               act = AR9; nxt = 4'd11;
            end
            else if (cur_state == 4'd10 && ev == EV_RELRP_R) begin
               act = AR10; nxt = 4'd12;
            end
            else if (rem) begin act = AA8; nxt = 4'd13; end
            else if (ev == EV_AB_L) begin act = AA1; nxt = 4'd13; end
            else if (ev == EV_AB_R) begin act = AA3; nxt = 4'd1; end
            else if (ev == EV_TC_CLOSED) begin act = AA4; nxt = 4'd1; end
            else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         act = AE1;
         nxt = cur_state;
      end
   end

   // action decode
   always_comb begin
      res = '0;
      res.new_state     = nxt;
      res.action_code   = act;
      res.abort_source  = stored_src;
      res.abort_reason  = stored_rsn;
      res.status        = base_status;
      res.no_transition = !ok;
      if (ok) begin
         case (act)
            AE1: res.transport_cmd = XCMD_OPEN;
            AE2: res.send_pdu_type = 3'd1;
            AE3: begin res.status = ST_ASSOC; res.indication = IND_AC; end
            AE4: begin
               res.status = ST_REJ; res.indication = IND_AC;
               res.transport_cmd = XCMD_CLOSE;
            end
            AE5: begin res.status = ST_CONN; res.timer_cmd = TCMD_START; end
            AE6: begin
               if (accept) begin
                  res.new_state = 4'd3; res.timer_cmd = TCMD_STOP;
                  res.indication = IND_RQ;
               end else begin
                  res.new_state = 4'd13; res.timer_cmd = TCMD_START;
                  res.send_pdu_type = 3'd3; res.indication = IND_RJ;
               end
            end
            AE7: res.send_pdu_type = 3'd2;
            AE8: begin res.send_pdu_type = 3'd3; res.timer_cmd = TCMD_START; end
            DT1: res.send_pdu_type = 3'd4;
            DT2: res.indication = IND_DATA;
            AR1: res.send_pdu_type = 3'd5;
            AR2: res.status = ST_REL;
            AR3: begin res.status = ST_REL; res.transport_cmd = XCMD_CLOSE; end
            AR4: begin res.send_pdu_type = 3'd6; res.timer_cmd = TCMD_START; end
            AR5: res.timer_cmd = TCMD_STOP;
            AR6: res.indication = IND_DATA;
            AR7: res.send_pdu_type = 3'd4;
            AR9: res.send_pdu_type = 3'd6;
            AR10: res.status = ST_REL;
            AA1: begin
               res.send_pdu_type = PDU_ABORT;
               res.timer_cmd = TCMD_START;
               if (ev == EV_AB_L) begin
                  res.abort_source = item_src; res.abort_reason = item_rsn;
               end else begin
                  res.abort_source = 8'd1; res.abort_reason = 8'd2;
               end
            end
            AA2: begin res.timer_cmd = TCMD_STOP; res.transport_cmd = XCMD_CLOSE; end
            AA3: begin res.status = ST_ABORT; res.transport_cmd = XCMD_CLOSE; end
            AA4: res.status = ST_ABORT;
            AA5: res.timer_cmd = TCMD_STOP;
            AA7: begin
               res.send_pdu_type = PDU_ABORT;
               res.abort_source = 8'd2; res.abort_reason = 8'd2;
            end
            AA8: begin
               res.send_pdu_type = PDU_ABORT;
               res.abort_source = 8'd2; res.abort_reason = 8'd2;
               res.status = ST_ABORT; res.timer_cmd = TCMD_START;
            end
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

[src/association_protocol_state_machine.sv]
`default_nettype none
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   func, pdu_type, accept_request, abort fields
// rsp_      out        rsp_valid/rsp_stall   state, action, commands, status, last
// csr_      in         APB write/read        artim_ticks at address 0
// A chained item holds req_stall high while its second result follows from the chain
// register, and until the output queue has room for that second result.
// Results leave through a two-entry output queue, so input is taken while one result waits; a full queue stalls input.
// Reset is synchronous: state 1, timer stopped, stored abort cleared, ARTIM 1000.
module association_protocol_state_machine #(
   parameter int TIMER_BITS = apsm_pkg::TIMER_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_pdu_type,
   input  wire logic        req_accept_request,
   input  wire logic [7:0]  req_abort_source,
   input  wire logic [7:0]  req_abort_reason,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_new_state,
   output logic [4:0]       rsp_action_code,
   output logic [2:0]       rsp_send_pdu_type,
   output logic [7:0]       rsp_reported_abort_source,
   output logic [7:0]       rsp_reported_abort_reason,
   output logic [1:0]       rsp_timer_cmd,
   output logic [1:0]       rsp_transport_cmd,
   output logic [2:0]       rsp_status,
   output logic [2:0]       rsp_indication,
   output logic             rsp_no_transition,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import apsm_pkg::*;

   typedef struct packed {
      result_type r;
      logic       last;
   } entry_type;

   // architectural state
   logic [3:0]            state_ff, state_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic                  run_ff, run_in;
   logic [7:0]            ssrc_ff, ssrc_in, srsn_ff, srsn_in;
   logic [15:0]           artim_ff;

   // chain register: second transition pending
   logic                  chain_ff, chain_in;
   event_type             cev_ff, cev_in;

   // output queue
   entry_type             q_ff [2];
   logic [1:0]            qcnt_ff, qcnt_in;

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {16'd0, artim_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) artim_ff <= ARTIM_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         artim_ff <= csr_pwdata[15:0];
   end

   // input decode
   event_type ev;
   logic      has_ev, is_tick;
   logic [2:0] base;
   logic [TIMER_BITS:0] next_cnt;
   logic      expire;
   always_comb begin
      ev = EV_INVALID;
      has_ev = 1'b1;
      base = ST_NONE;
      is_tick = 1'b0;
      next_cnt = {1'b0, count_ff} + 1'b1;
      expire = (next_cnt >= {{(TIMER_BITS+1){1'b0}}, artim_ff}
                || next_cnt[TIMER_BITS]);
      case (req_func)
         FUNC_SEND, FUNC_RECV: begin
            if (req_pdu_type >= 8'd1 && req_pdu_type <= 8'd7)
               ev = event_type'({(req_pdu_type[3:0] - 4'd1), req_func[0]});
         end
         FUNC_TC_IND: ev = EV_TC_IND;
         FUNC_TC_CLOSED: begin ev = EV_TC_CLOSED; base = ST_CLOSED; end
         FUNC_TICK: begin
            ev = EV_ARTIM; is_tick = 1'b1;
            has_ev = run_ff && expire;
         end
         default: has_ev = 1'b0;
      endcase
   end

   // stored abort seen by this transaction
   logic [7:0] src_now, rsn_now;
   logic       store_ab;
   assign store_ab = (req_func == FUNC_SEND || req_func == FUNC_RECV)
                     && req_pdu_type == 8'd7;
   assign src_now = store_ab ? req_abort_source : ssrc_ff;
   assign rsn_now = store_ab ? req_abort_reason : srsn_ff;

   // shared transition unit: chain step or new item
   event_type  u_ev;
   logic [2:0] u_base;
   result_type u_res;
   assign u_ev   = chain_ff ? cev_ff : ev;
   assign u_base = chain_ff ? ST_NONE : base;

   apsm_step u_step (
      .cur_state  (state_ff),
      .ev         (u_ev),
      .base_status(u_base),
      .accept     (req_accept_request),
      .item_src   (req_abort_source),
      .item_rsn   (req_abort_reason),
      .stored_src (chain_ff ? ssrc_ff : src_now),
      .stored_rsn (chain_ff ? srsn_ff : rsn_now),
      .res        (u_res)
   );

   logic room, take, emit, want_chain, pop;
   assign pop       = rsp_valid && !rsp_stall;
   // queue slot must be free even if nothing pops
   assign room      = (qcnt_ff == 2'd0) || (qcnt_ff == 2'd1);
   assign req_stall = chain_ff || !room;
   assign take      = req_valid && !req_stall;
   assign want_chain = !u_res.no_transition &&
                       (u_ev == EV_RQ_L || u_res.action_code == AR2);
   assign emit      = chain_ff ? room : (take && has_ev);

   // state update
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      run_in   = run_ff;
      ssrc_in  = ssrc_ff;
      srsn_in  = srsn_ff;
      chain_in = chain_ff;
      cev_in   = cev_ff;
      if (take && store_ab) begin
         ssrc_in = req_abort_source;
         srsn_in = req_abort_reason;
      end
      if (take && is_tick && run_ff && !expire) count_in = next_cnt[TIMER_BITS-1:0];
      if (take && is_tick && run_ff && expire) begin
         run_in = 1'b0; count_in = '0;
      end
      if (emit) begin
         state_in = u_res.new_state;
         if (u_res.timer_cmd == TCMD_START) begin run_in = 1'b1; count_in = '0; end
         if (u_res.timer_cmd == TCMD_STOP) begin run_in = 1'b0; count_in = '0; end
         if (chain_ff) chain_in = 1'b0;
         else if (want_chain) begin
            chain_in = 1'b1;
            cev_in = (u_ev == EV_RQ_L) ? EV_TC_CONF : EV_RELRP_L;
         end
      end
   end

   // AE-6 stops the timer even when it restarts it; start covers that
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 4'd1;
         count_ff <= '0;
         run_ff   <= 1'b0;
         ssrc_ff  <= 8'd0;
         srsn_ff  <= 8'd0;
         chain_ff <= 1'b0;
         cev_ff   <= EV_TC_CONF;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_ff   <= run_in;
         ssrc_ff  <= ssrc_in;
         srsn_ff  <= srsn_in;
         chain_ff <= chain_in;
         cev_ff   <= cev_in;
      end
   end

   // output queue, two entries
   entry_type ent;
   assign ent.r = u_res;
   assign ent.last = chain_ff || !want_chain;
   always_comb begin
      qcnt_in = qcnt_ff - {1'b0, pop} + {1'b0, emit};
   end
   always_ff @(posedge clock) begin
      if (reset) qcnt_ff <= 2'd0;
      else qcnt_ff <= qcnt_in;
   end
   always_ff @(posedge clock) begin
      if (pop) q_ff[0] <= (emit && !qcnt_ff[1]) ? ent : q_ff[1];
      if (emit && pop && qcnt_ff[1]) q_ff[1] <= ent;
      if (emit && !pop) q_ff[qcnt_ff[0]] <= ent;
   end

   assign rsp_valid                 = qcnt_ff != 2'd0;
   assign rsp_new_state             = q_ff[0].r.new_state;
   assign rsp_action_code           = q_ff[0].r.action_code;
   assign rsp_send_pdu_type         = q_ff[0].r.send_pdu_type;
   assign rsp_reported_abort_source = q_ff[0].r.abort_source;
   assign rsp_reported_abort_reason = q_ff[0].r.abort_reason;
   assign rsp_timer_cmd             = q_ff[0].r.timer_cmd;
   assign rsp_transport_cmd         = q_ff[0].r.transport_cmd;
   assign rsp_status                = q_ff[0].r.status;
   assign rsp_indication            = q_ff[0].r.indication;
   assign rsp_no_transition         = q_ff[0].r.no_transition;
   assign rsp_last                  = q_ff[0].last;

   // checks
   a_qcnt: assert property (@(posedge clock) disable iff (reset) qcnt_ff != 2'd3)
      else $error("queue overflow");
   a_state: assert property (@(posedge clock) disable iff (reset)
      state_ff >= 4'd1 && state_ff <= 4'd13) else $error("bad state");
   a_chain: assert property (@(posedge clock) disable iff (reset)
      chain_ff |-> req_stall) else $error("input taken during chain");
   a_run: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> count_ff == '0) else $error("stopped timer counts");

endmodule
`default_nettype wire

[verif/association_protocol_state_machine_tb.sv]
`timescale 1ns / 100ps
module association_protocol_state_machine_tb;
   import apsm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] ADDR_ARTIM = 2'd0;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] pdu_type;
      logic       accept_request;
      logic [7:0] abort_source;
      logic [7:0] abort_reason;
   } event_item_type;

   typedef struct packed {
      result_type outcome;
      logic       last;
   } outcome_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_func;
   logic [7:0] req_pdu_type;
   logic req_accept_request;
   logic [7:0] req_abort_source;
   logic [7:0] req_abort_reason;
   logic rsp_valid;
   logic rsp_stall;
   logic [3:0] rsp_new_state;
   logic [4:0] rsp_action_code;
   logic [2:0] rsp_send_pdu_type;
   logic [7:0] rsp_reported_abort_source;
   logic [7:0] rsp_reported_abort_reason;
   logic [1:0] rsp_timer_cmd;
   logic [1:0] rsp_transport_cmd;
   logic [2:0] rsp_status;
   logic [2:0] rsp_indication;
   logic rsp_no_transition;
   logic rsp_last;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   association_protocol_state_machine DUT (.*);

   // predictor state
   logic [15:0] model_artim;
   logic [3:0]  model_state;
   logic [16:0] model_count;
   logic        model_running;
   logic [7:0]  model_abort_src;
   logic [7:0]  model_abort_rsn;

   outcome_type expected_outcomes[$];
   int mismatch_count;
   int transaction_count;
   int outcome_count;
   int idle_cycles;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_receiver;
   bit timed_out;
   int state_visits[16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit remote_event(event_type ev);
      return ev == EV_AC_R || ev == EV_RJ_R || ev == EV_RQ_R || ev == EV_DT_R ||
             ev == EV_RELRQ_R || ev == EV_RELRP_R;
   endfunction

   // transition table; returns 1 when an entry exists
   function automatic bit find_transition(logic [3:0] s, event_type ev,
                                          output logic [4:0] act, output logic [3:0] nxt);
      bit remote_or_bad;
      remote_or_bad = remote_event(ev) || ev == EV_INVALID;
      act = AE1;
      nxt = s;
      case (s)
         4'd1: begin
            if (ev == EV_RQ_L) begin act = AE1; nxt = 4; return 1; end
            if (ev == EV_TC_IND) begin act = AE5; nxt = 2; return 1; end
            return 0;
         end
         4'd2: begin
            if (ev == EV_RQ_R) begin act = AE6; nxt = 3; return 1; end
            if (remote_or_bad) begin act = AA1; nxt = 13; return 1; end
            if (ev == EV_AB_R || ev == EV_ARTIM) begin act = AA2; nxt = 1; return 1; end
            if (ev == EV_TC_CLOSED) begin act = AA5; nxt = 1; return 1; end
            return 0;
         end
         4'd4: begin
            if (ev == EV_TC_CONF) begin act = AE2; nxt = 5; return 1; end
            if (ev == EV_AB_L) begin act = AA2; nxt = 1; return 1; end
            if (ev == EV_TC_CLOSED) begin act = AA4; nxt = 1; return 1; end
            return 0;
         end
         4'd13: begin
            if (ev == EV_RQ_R || ev == EV_INVALID) begin act = AA7; nxt = 13; return 1; end
            if (remote_event(ev)) begin act = AA6; nxt = 13; return 1; end
            if (ev == EV_AB_R || ev == EV_ARTIM) begin act = AA2; nxt = 1; return 1; end
            if (ev == EV_TC_CLOSED) begin act = AR5; nxt = 1; return 1; end
            return 0;
         end
         default: ;
      endcase
      if (s < 3 || s > 12) return 0;
      if (s == 3 && ev == EV_AC_L) begin act = AE7; nxt = 6; return 1; end
      if (s == 3 && ev == EV_RJ_L) begin act = AE8; nxt = 13; return 1; end
      if (s == 5 && ev == EV_AC_R) begin act = AE3; nxt = 6; return 1; end
      if (s == 5 && ev == EV_RJ_R) begin act = AE4; nxt = 1; return 1; end
      if (s == 6 && ev == EV_DT_L) begin act = DT1; nxt = 6; return 1; end
      if (s == 6 && ev == EV_DT_R) begin act = DT2; nxt = 6; return 1; end
      if (s == 6 && ev == EV_RELRQ_L) begin act = AR1; nxt = 7; return 1; end
      if (s == 6 && ev == EV_RELRQ_R) begin act = AR2; nxt = 8; return 1; end
      if (s == 7 && ev == EV_DT_R) begin act = AR6; nxt = 7; return 1; end
      if (s == 7 && ev == EV_RELRQ_R) return 0;
      if ((s == 7 || s == 11) && ev == EV_RELRP_R) begin act = AR3; nxt = 1; return 1; end
      if (s == 8 && ev == EV_DT_L) begin act = AR7; nxt = 8; return 1; end
      if ((s == 8 || s == 12) && ev == EV_RELRP_L) begin act = AR4; nxt = 13; return 1; end
      if (s == 9 && ev == EV_RELRP_L) begin act = AR9; nxt = 11; return 1; end
      if (s == 10 && ev == EV_RELRP_R) begin act = AR10; nxt = 12; return 1; end
      if (remote_or_bad) begin act = AA8; nxt = 13; return 1; end
      if (ev == EV_AB_L) begin act = AA1; nxt = 13; return 1; end
      if (ev == EV_AB_R) begin act = AA3; nxt = 1; return 1; end
      if (ev == EV_TC_CLOSED) begin act = AA4; nxt = 1; return 1; end
      return 0;
   endfunction

   // applies one transition to the predictor state and builds its outcome
   function automatic result_type apply_transition(event_type ev, logic [2:0] base_status,
                                                   event_item_type it);
      result_type r;
      logic [4:0] act;
      logic [3:0] nxt;
      bit found;
      r = '0;
      r.status = base_status;
      r.abort_source = model_abort_src;
      r.abort_reason = model_abort_rsn;
      found = find_transition(model_state, ev, act, nxt);
      if (found) begin
         model_state = nxt;
         case (act)
            AE1: r.transport_cmd = XCMD_OPEN;
            AE2: r.send_pdu_type = 3'd1;
            AE3: begin r.status = ST_ASSOC; r.indication = IND_AC; end
            AE4: begin
               r.status = ST_REJ; r.indication = IND_AC; r.transport_cmd = XCMD_CLOSE;
            end
            AE5: begin
               r.status = ST_CONN; r.timer_cmd = TCMD_START;
               model_running = 1; model_count = 0;
            end
            AE6: begin
               model_running = 0; model_count = 0;
               if (it.accept_request) begin
                  model_state = 3; r.timer_cmd = TCMD_STOP; r.indication = IND_RQ;
               end else begin
                  model_state = 13; r.timer_cmd = TCMD_START;
                  model_running = 1; r.send_pdu_type = 3'd3; r.indication = IND_RJ;
               end
            end
            AE7: r.send_pdu_type = 3'd2;
            AE8: begin
               r.send_pdu_type = 3'd3; r.timer_cmd = TCMD_START;
               model_running = 1; model_count = 0;
            end
            DT1: r.send_pdu_type = 3'd4;
            DT2: r.indication = IND_DATA;
            AR1: r.send_pdu_type = 3'd5;
            AR2: r.status = ST_REL;
            AR3: begin r.status = ST_REL; r.transport_cmd = XCMD_CLOSE; end
            AR4: begin
               r.send_pdu_type = 3'd6; r.timer_cmd = TCMD_START;
               model_running = 1; model_count = 0;
            end
            AR5: begin r.timer_cmd = TCMD_STOP; model_running = 0; model_count = 0; end
            AR6: r.indication = IND_DATA;
            AR7: r.send_pdu_type = 3'd4;
            AR9: r.send_pdu_type = 3'd6;
            AR10: r.status = ST_REL;
            AA1: begin
               r.send_pdu_type = PDU_ABORT;
               if (ev == EV_AB_L) begin
                  r.abort_source = it.abort_source; r.abort_reason = it.abort_reason;
               end else begin
                  r.abort_source = 8'd1; r.abort_reason = 8'd2;
               end
               r.timer_cmd = TCMD_START; model_running = 1; model_count = 0;
            end
            AA2: begin
               r.timer_cmd = TCMD_STOP; r.transport_cmd = XCMD_CLOSE;
               model_running = 0; model_count = 0;
            end
            AA3: begin r.status = ST_ABORT; r.transport_cmd = XCMD_CLOSE; end
            AA4: r.status = ST_ABORT;
            AA5: begin r.timer_cmd = TCMD_STOP; model_running = 0; model_count = 0; end
            AA7: begin
               r.send_pdu_type = PDU_ABORT; r.abort_source = 8'd2; r.abort_reason = 8'd2;
            end
            AA8: begin
               r.send_pdu_type = PDU_ABORT; r.abort_source = 8'd2; r.abort_reason = 8'd2;
               r.status = ST_ABORT; r.timer_cmd = TCMD_START;
               model_running = 1; model_count = 0;
            end
            default: ;
         endcase
         r.action_code = act;
      end
      r.new_state = model_state;
      r.no_transition = !found;
      return r;
   endfunction

   // works out the outcomes of one accepted transaction
   task automatic predict_outcomes(event_item_type it);
      event_type ev;
      logic [2:0] base;
      result_type first_r;
      outcome_type o;
      base = ST_NONE;
      if (it.func == FUNC_SEND || it.func == FUNC_RECV) begin
         if (it.pdu_type == 8'd7) begin
            model_abort_src = it.abort_source;
            model_abort_rsn = it.abort_reason;
         end
         case (it.pdu_type)
            8'd1: ev = it.func == FUNC_SEND ? EV_RQ_L : EV_RQ_R;
            8'd2: ev = it.func == FUNC_SEND ? EV_AC_L : EV_AC_R;
            8'd3: ev = it.func == FUNC_SEND ? EV_RJ_L : EV_RJ_R;
            8'd4: ev = it.func == FUNC_SEND ? EV_DT_L : EV_DT_R;
            8'd5: ev = it.func == FUNC_SEND ? EV_RELRQ_L : EV_RELRQ_R;
            8'd6: ev = it.func == FUNC_SEND ? EV_RELRP_L : EV_RELRP_R;
            8'd7: ev = it.func == FUNC_SEND ? EV_AB_L : EV_AB_R;
            default: ev = EV_INVALID;
         endcase
      end else if (it.func == FUNC_TC_IND) begin
         ev = EV_TC_IND;
      end else if (it.func == FUNC_TC_CLOSED) begin
         ev = EV_TC_CLOSED;
         base = ST_CLOSED;
      end else if (it.func == FUNC_TICK) begin
         if (!model_running) return;
         if (model_count + 1 >= {1'b0, model_artim} || model_count + 1 > 17'hFFFF) begin
            model_running = 0; model_count = 0;
            ev = EV_ARTIM;
         end else begin
            model_count = 17'(model_count + 1);
            return;
         end
      end else begin
         return;
      end
      first_r = apply_transition(ev, base, it);
      state_visits[model_state]++;
      if (!first_r.no_transition && (ev == EV_RQ_L || first_r.action_code == AR2)) begin
         o.outcome = first_r; o.last = 0;
         expected_outcomes.push_back(o);
         o.outcome = apply_transition(ev == EV_RQ_L ? EV_TC_CONF : EV_RELRP_L, ST_NONE, it);
         o.last = 1;
         expected_outcomes.push_back(o);
      end else begin
         o.outcome = first_r; o.last = 1;
         expected_outcomes.push_back(o);
      end
   endtask

   // offers one transaction and waits until it is taken
   task automatic send_event(event_item_type it);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
         @(negedge clock);
      req_valid = 1'b1;
      req_func = it.func;
      req_pdu_type = it.pdu_type;
      req_accept_request = it.accept_request;
      req_abort_source = it.abort_source;
      req_abort_reason = it.abort_reason;
      do @(posedge clock); while (req_stall);
      predict_outcomes(it);
      transaction_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_pdu(logic [2:0] f, logic [7:0] t);
      event_item_type it;
      it.func = f;
      it.pdu_type = t;
      it.accept_request = 1'($urandom_range(1, 0));
      it.abort_source = 8'($urandom);
      it.abort_reason = 8'($urandom);
      send_event(it);
   endtask

   task automatic wait_drained();
      while (expected_outcomes.size() != 0 && !timed_out) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_artim(logic [15:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_ARTIM; csr_pwdata <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      model_artim = value;
   endtask

   // receiver stall process
   always @(negedge clock) begin
      if (hold_receiver) rsp_stall <= 1'b1;
      else rsp_stall <= recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct;
   end

   // outcome checker
   always @(posedge clock) begin
      outcome_type exp_o;
      outcome_type got_o;
      if (!reset && rsp_valid && !rsp_stall) begin
         outcome_count++;
         got_o.outcome = {rsp_new_state, rsp_action_code, rsp_send_pdu_type,
                          rsp_reported_abort_source, rsp_reported_abort_reason,
                          rsp_timer_cmd, rsp_transport_cmd, rsp_status, rsp_indication,
                          rsp_no_transition};
         got_o.last = rsp_last;
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction: %p", got_o);
         end else begin
            exp_o = expected_outcomes.pop_front();
            if (got_o !== exp_o) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", exp_o, got_o);
            end
         end
      end
   end

   // watchdog on cycles with work pending but no transaction taken or popped
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else if (req_valid || expected_outcomes.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
         end
      end else idle_cycles <= 0;
   end

   // drives a named state from idle by a well formed sequence
   task automatic reach_state(int target);
      send_pdu(FUNC_TC_CLOSED, 8'd0);
      if (model_state != 1) send_pdu(FUNC_TC_CLOSED, 8'd0);
      if (target == 5) send_pdu(FUNC_SEND, 8'd1);
      else if (target == 6 || target == 7 || target == 8) begin
         send_pdu(FUNC_SEND, 8'd1);
         send_pdu(FUNC_RECV, 8'd2);
         if (target == 7) send_pdu(FUNC_SEND, 8'd5);
         if (target == 8) send_pdu(FUNC_RECV, 8'd5);
      end else if (target == 2 || target == 3) begin
         send_pdu(FUNC_TC_IND, 8'd0);
         if (target == 3) send_event('{FUNC_RECV, 8'd1, 1'b1, 8'd0, 8'd0});
      end
   endtask

   task automatic test_directed();
      send_pdu(FUNC_TICK, 8'd0);
      send_event('{3'd5, 8'hFF, 1'b1, 8'hFF, 8'hFF});
      send_event('{3'd7, 8'h00, 1'b0, 8'h00, 8'h00});
      send_pdu(FUNC_RECV, 8'd4);
      send_pdu(FUNC_SEND, 8'd1);
      send_pdu(FUNC_RECV, 8'd2);
      send_pdu(FUNC_SEND, 8'd4);
      send_pdu(FUNC_RECV, 8'd4);
      send_pdu(FUNC_RECV, 8'd5);
      send_pdu(FUNC_SEND, 8'd4);
      send_pdu(FUNC_SEND, 8'd6);
      send_pdu(FUNC_RECV, 8'd0);
      send_pdu(FUNC_RECV, 8'd7);
      send_pdu(FUNC_TC_IND, 8'd0);
      send_event('{FUNC_RECV, 8'd1, 1'b0, 8'h00, 8'hFF});
      send_pdu(FUNC_RECV, 8'hFF);
      send_pdu(FUNC_TC_CLOSED, 8'd0);
      send_pdu(FUNC_TC_IND, 8'd0);
      send_event('{FUNC_RECV, 8'd1, 1'b1, 8'hFF, 8'h00});
      send_pdu(FUNC_SEND, 8'd3);
      send_pdu(FUNC_TC_CLOSED, 8'd0);
      send_pdu(FUNC_TC_IND, 8'd0);
      send_event('{FUNC_RECV, 8'd1, 1'b1, 8'h5A, 8'hA5});
      send_event('{FUNC_SEND, 8'd7, 1'b0, 8'hA5, 8'h5A});
      send_pdu(FUNC_TC_CLOSED, 8'd0);
   endtask

   // timer expiry for one timer length; the calls cover 0, 1, 3, 7 and 200
   task automatic test_artim(logic [15:0] ticks);
      wait_drained();
      write_artim(ticks);
      send_pdu(FUNC_TC_IND, 8'd0);
      repeat (ticks + 1) send_pdu(FUNC_TICK, 8'd0);
      send_pdu(FUNC_TC_CLOSED, 8'd0);
   endtask

   // random sequences, mostly well formed, for one idling phase
   task automatic test_random(int count, int send_pct, int recv_pct);
      event_item_type it;
      int k;
      wait_drained();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (k = 0; k < count; k++) begin
         it.accept_request = 1'($urandom_range(1, 0));
         it.abort_source = 8'($urandom);
         it.abort_reason = 8'($urandom);
         case ($urandom_range(9, 0))
            0: begin it.func = 3'($urandom_range(7, 0)); it.pdu_type = 8'($urandom); end
            1: begin it.func = FUNC_TICK; it.pdu_type = 8'($urandom); end
            2: begin it.func = FUNC_TC_IND; it.pdu_type = 8'($urandom); end
            3: begin it.func = FUNC_TC_CLOSED; it.pdu_type = 8'($urandom); end
            default: begin
               it.func = 3'($urandom_range(1, 0));
               it.pdu_type = 8'($urandom_range(7, 1));
            end
         endcase
         if (model_state == 1 && $urandom_range(2, 0) == 0) begin
            it.func = $urandom_range(1, 0) ? FUNC_SEND : FUNC_TC_IND;
            it.pdu_type = 8'd1;
         end
         send_event(it);
      end
   endtask

   // receiver held off while the sender keeps offering
   task automatic test_backpressure();
      int k;
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_receiver = 1;
      fork
         begin
            repeat (200) @(negedge clock);
            hold_receiver = 0;
         end
         for (k = 0; k < 30; k++) send_pdu(FUNC_SEND, 8'(1 + (k % 2) * 3));
      join
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_func = '0; req_pdu_type = '0; req_accept_request = 1'b0;
      req_abort_source = '0; req_abort_reason = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      hold_receiver = 0; send_idle_pct = 0; recv_stall_pct = 0;
      mismatch_count = 0; transaction_count = 0; outcome_count = 0;
      idle_cycles = 0; timed_out = 0;
      model_artim = ARTIM_RESET; model_state = 4'd1; model_count = 0;
      model_running = 0; model_abort_src = 0; model_abort_rsn = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_artim(16'd1);
      test_artim(16'd0);
      test_artim(16'd7);
      test_artim(16'd200);
      test_artim(16'd3);
      test_random(350, 0, 0);
      test_random(350, 60, 0);
      test_backpressure();
      test_random(350, 0, 60);
      test_random(350, 24, 24);
      wait_drained();
      repeat (20) @(negedge clock);
      $display("sent %0d transactions, checked %0d outcomes across four idling phases,",
               transaction_count, outcome_count);
      $display("timer lengths 0 to 200 and a long receiver hold-off");
      if (mismatch_count == 0 && expected_outcomes.size() == 0)
         $display("Regression PASS");
      else begin
         $display("%0d mismatches, %0d outcomes missing", mismatch_count,
                  expected_outcomes.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
